[src/pfc_pkg.sv]
// Shared types and constants for the prime factor count unit.
package pfc_pkg;

	localparam int COUNT_W = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // take a new request and start the first trial division
		logic step;     // one restoring-division step
		logic take;     // divisor divides the remainder: keep the quotient, count it
		logic next_d;   // divisor does not divide: try the next divisor
		logic out_load; // capture the final count into the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;   // the division in flight is on its last step
		logic trial_over; // divisor squared exceeds the remainder
		logic rem_zero;   // the trial divisor divides the remainder
	} sts_t;

endpackage

[src/pfc_dpath.sv]
// Datapath: remainder, divisor, count and a shared bit-serial divider.
module pfc_dpath #(
	parameter int W = 32
) (
	input  logic                          clk,
	input  pfc_pkg::cmd_t                 cmd,
	input  logic signed [W-1:0]           value,
	output pfc_pkg::sts_t                 sts,
	output logic [pfc_pkg::COUNT_W-1:0]   factor_count
);

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] STEP_LAST = CW'(W - 1);

	logic [W-1:0]                 n_q;
	logic [W-1:0]                 d_q;
	logic [pfc_pkg::COUNT_W-1:0]  count_q;
	logic [W-1:0]                 rem_q;
	logic [W-1:0]                 quo_q;
	logic [CW-1:0]                step_q;
	logic [pfc_pkg::COUNT_W-1:0]  factor_count_q;

	logic [W-1:0]                 vin;
	logic [W:0]                   div_trial;
	logic [W+1:0]                 div_diff;
	logic                         div_ge;
	logic [W-1:0]                 rem_new;
	logic [pfc_pkg::COUNT_W-1:0]  count_inc;
	logic [pfc_pkg::COUNT_W-1:0]  count_final;

	always_comb begin
		// Negative values factor as zero, which yields no factors.
		vin = value[W-1] ? '0 : W'(unsigned'(value));
		div_trial = {rem_q, quo_q[W-1]};
		div_diff = {1'b0, div_trial} - {2'b00, d_q};
		div_ge = !div_diff[W+1];
		rem_new = div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
		count_inc = (count_q == pfc_pkg::COUNT_MAX) ? pfc_pkg::COUNT_MAX
			: count_q + pfc_pkg::COUNT_W'(1);
		count_final = (n_q > W'(1)) ? count_inc : count_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= vin;
			d_q     <= W'(2);
			count_q <= '0;
			rem_q   <= '0;
			quo_q   <= vin;
			step_q  <= STEP_LAST;
		end else if (cmd.take) begin
			n_q     <= quo_q;
			count_q <= count_inc;
			rem_q   <= '0;
			step_q  <= STEP_LAST;
		end else if (cmd.next_d) begin
			d_q    <= d_q + W'(1);
			rem_q  <= '0;
			quo_q  <= n_q;
			step_q <= STEP_LAST;
		end else if (cmd.step) begin
			rem_q  <= rem_new;
			quo_q  <= {quo_q[W-2:0], div_ge};
			step_q <= step_q - CW'(1);
		end
		if (cmd.out_load) begin
			factor_count_q <= count_final;
		end
	end

	// After a full division quo_q holds the quotient, so d > n/d is d > quo_q.
	assign sts.div_last   = (step_q == '0);
	assign sts.trial_over = (d_q > quo_q);
	assign sts.rem_zero   = (rem_q == '0);
	assign factor_count   = factor_count_q;

endmodule

[src/pfc_ctrl.sv]
// Controller: sequences trial divisions and owns both handshakes.
module pfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pfc_pkg::sts_t sts,
	output pfc_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		out_free = !out_valid_q || out_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.trial_over) begin
					state_d = ST_FINISH;
				end else if (sts.rem_zero) begin
					cmd.take = 1'b1;
					state_d  = ST_DIV;
				end else begin
					cmd.next_d = 1'b1;
					state_d    = ST_DIV;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/prime_factor_count_unit.sv]
// After acceptance the unit runs a division for each trial and then captures the result.
// Each division is a VALUE_WIDTH-step restoring division followed by a check state.
// A new request is taken only in idle, after the last result is captured into a free output.
// A prime near 2^31 needs about 46340 divisions.
// The next request is taken while the last result waits; reset (arst_n low,
// asynchronous) returns the controller to idle and empties the output.
module prime_factor_count_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [VALUE_WIDTH-1:0]      value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pfc_pkg::COUNT_W-1:0]        factor_count
);

	// The controller and datapath talk only through these two structs.
	pfc_pkg::cmd_t cmd;
	pfc_pkg::sts_t sts;

	// The controller walks each request through trial divisions: a full
	// division of the remainder by the current divisor gives both the
	// quotient, which decides whether the divisor still lies at or below
	// the square root, and the remainder, which says whether it divides.
	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the remainder, divisor, running count and the
	// result register, which frees the controller for the next request.
	pfc_dpath #(
		.W (VALUE_WIDTH)
	) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.value        (value),
		.sts          (sts),
		.factor_count (factor_count)
	);

	// A new request is only loaded when the input handshake completes.
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && in_ready))
		else $error("request loaded without an input handshake");

	// Once a request is taken the block is busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready while a request is in work");

	// A factor is only taken when the divisor divides and is within range.
	a_take_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (sts.rem_zero && !sts.trial_over))
		else $error("factor taken on a failed trial");

	// Capturing a result always presents it in the next cycle.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("captured result not presented");

endmodule

[tb/factor_count_checker.sv]
// Checker for the prime factor count unit: watches both channels and compares each result.
module factor_count_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [pfc_pkg::COUNT_W-1:0]   factor_count,
	output int                            mismatches,
	output int                            outstanding
);

	logic [pfc_pkg::COUNT_W-1:0] expected_counts [$];
	int errs = 0;

	// Prime factors with multiplicity, found by trial division; below two gives zero.
	function automatic logic [pfc_pkg::COUNT_W-1:0] big_omega_of(
		logic signed [VALUE_WIDTH-1:0] v
	);
		longint unsigned rem;
		longint unsigned divisor;
		longint unsigned found;
		if (v < 2)
			return '0;
		rem = longint'(v);
		divisor = 2;
		found = 0;
		while (divisor <= rem / divisor) begin
			if (rem % divisor == 0) begin
				rem = rem / divisor;
				found++;
			end else begin
				divisor++;
			end
		end
		if (rem > 1)
			found++;
		if (found > pfc_pkg::COUNT_MAX)
			found = pfc_pkg::COUNT_MAX;
		return found[pfc_pkg::COUNT_W-1:0];
	endfunction

	always @(posedge clk) begin : watch
		logic [pfc_pkg::COUNT_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_counts.size() == 0) begin
					$error("factor_count: got %0d with no request outstanding", factor_count);
					errs++;
				end else begin
					want = expected_counts.pop_front();
					if (factor_count !== want) begin
						$error("factor_count: expected %0d, actual %0d", want, factor_count);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_counts = {expected_counts, big_omega_of(value)};
		end
		mismatches <= errs;
		outstanding <= expected_counts.size();
	end

endmodule

[tb/prime_factor_count_unit_tb.sv]
// Testbench top for the prime factor count unit: stimulus, handshake pacing and verdict.
module prime_factor_count_unit_tb;

	localparam int VALUE_WIDTH = 32;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          out_valid;
	logic                          out_ready;
	logic [pfc_pkg::COUNT_W-1:0]   factor_count;

	int mismatches;
	int outstanding;

	// Percent of cycles in which the sender holds back a request, and in which
	// the receiver refuses a result. Changed between phases of the run.
	int feed_idle_pct  = 0;
	int drain_idle_pct = 0;

	// Directed values: both ends of the signed range, the values below two,
	// the largest count that fits in 32 bits (a power of two), a high power
	// of three, prime squares where trials stop exactly at the root, a
	// 16-bit prime, alternating bit patterns, and numbers with many distinct
	// small factors. The largest positive value is a prime, so that one
	// request runs the full trial sweep and dominates the run time.
	int directed_values [20] = '{
		0, 1, 2, 3, 4, -1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
		32'h4000_0000, 1162261467, 961, 32'h3FFF_FFFF, 65521,
		32'h5555_5555, 32'hAAAA_AAAA, 30030, 6, 9, 65536
	};

	prime_factor_count_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.factor_count(factor_count)
	);

	factor_count_checker #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.factor_count(factor_count),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The receiver decides afresh at every falling edge whether it takes a
	// result at the next rising edge. With zero idling it is always ready.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= drain_idle_pct);
	end

	// Random values are kept cheap for the block: the cost of a request grows
	// with the square root of its largest prime factor, so most values are
	// products of small factors. Products are capped at a random power of
	// two so that every magnitude, up to bit 30, shows up. Negative values
	// cover the sign bit and return right away.
	function automatic int draw_value();
		int pick;
		longint unsigned prod;
		longint unsigned ceiling;
		longint unsigned f;
		pick = $urandom_range(99);
		if (pick < 60) begin
			ceiling = (64'd1 << $urandom_range(31, 2)) - 1;
			prod = 1;
			repeat (40) begin
				f = $urandom_range(97, 2);
				if (prod * f > ceiling)
					break;
				prod = prod * f;
			end
			// Some products get one larger cofactor, prime or not.
			if (pick >= 45) begin
				f = $urandom_range(4095, 2);
				if (prod * f <= 64'h7FFF_FFFF)
					prod = prod * f;
			end
			return int'(prod[31:0]);
		end
		if (pick < 80)
			return int'($urandom | 32'h8000_0000);
		if (pick < 92)
			return int'($urandom_range(65535, 0));
		return int'($urandom_range(3, 0));
	endfunction

	// Offer one request. Random idle cycles come first, with valid low; then
	// valid rises with the value and both hold until the block accepts it.
	// At most one assignment to valid is made at each falling edge.
	task automatic offer_value(input int v);
		@(negedge clk);
		while ($urandom_range(99) < feed_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	initial begin
		in_valid = 1'b0;
		value = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Three phases: a slow receiver, then a slow sender, then full speed.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					feed_idle_pct = 21;
					drain_idle_pct = 66;
				end
				1: begin
					feed_idle_pct = 66;
					drain_idle_pct = 21;
				end
				default: begin
					feed_idle_pct = 0;
					drain_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				foreach (directed_values[i])
					offer_value(directed_values[i]);
			end
			repeat (27)
				offer_value(draw_value());
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain: every request yields one result, so wait for the last one,
		// then watch a while longer for any stray result.
		while (outstanding != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Most of the slowest correct run is the one full trial sweep for the largest
	// prime; the timeout allows several times that run.
	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
src/pfc_pkg.sv
src/pfc_dpath.sv
src/pfc_ctrl.sv
src/prime_factor_count_unit.sv
tb/factor_count_checker.sv
tb/prime_factor_count_unit_tb.sv
